[hdl/svn_pkg.sv]
// Shared types and constants for the smooth vertex normal unit.
// Used by smooth_vertex_normals; depends on nothing.
package svn_pkg;

	localparam int IN_DATA_W  = 144;
	localparam int IN_USER_W  = 2;
	localparam int IDX_W      = 12;
	localparam int POS_W      = 32;
	localparam int MULW       = 32;
	localparam int SUM_W      = 32;
	localparam int CNT_W      = 16;
	localparam int VEC_W      = 65;
	localparam int SUM_WORD_W = 3 * SUM_W + CNT_W;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TRI   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_DEGEN  = 2'd1,
		STAT_UNUSED = 2'd2
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_TRI_A,
		ST_TRI_B,
		ST_TRI_C,
		ST_TRI_EDGE,
		ST_MUL,
		ST_CROSS,
		ST_NORM,
		ST_SQR,
		ST_ROOT_GO,
		ST_ROOT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_RD_ISSUE,
		ST_RD_SUM,
		ST_DONE
	} state_t;

endpackage

[hdl/smooth_vertex_normals.sv]
// Smooth vertex normal unit: sequencer, shared 32x32 multiplier and stores.
// Depends on svn_pkg, svn_ram, svn_isqrt and svn_div.
//
// The block keeps one mesh: vertex positions in a position store and, per vertex,
// a running sum of unit face normals plus a use count in a sum store. Each input
// word carries an opcode in tuser: load writes one vertex position; add triangle
// forms the exact cross product of the edge vectors from the first corner, scales it
// to a Q1.(NORMAL_WIDTH-1) unit normal and adds it, saturating, to its three
// corners; read returns the scaled sum of one vertex; clear zeroes all sums and
// counts. Every input word yields exactly one result word. A degenerate or out of
// range triangle is skipped with status 1; an unused, zero or out of range read
// gives a zero vector with status 2. One item is in work at a time and s_axis
// tready is low meanwhile; a finished result waits in the output register, so the
// next word is taken while it is pending. A clear writes one sum-store row per
// cycle; a triangle or a read normalizes its vector by shifts, then runs a
// bit-serial square root and three divisions. After reset the block runs the
// same clearing pass with tready low before it takes its first word.
module smooth_vertex_normals #(
	parameter int MAX_VERTICES = 4096,
	parameter int COORD_WIDTH  = 32,
	parameter int NORMAL_WIDTH = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// vertex_index, pos_x_in, pos_y_in, pos_z_in, corner_a, corner_b, corner_c
	input  logic [svn_pkg::IN_DATA_W-1:0]               s_axis_tdata,
	// opcode
	input  logic [svn_pkg::IN_USER_W-1:0]               s_axis_tuser,
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// normal_x, normal_y, normal_z, status, zero pad
	output logic [((3*NORMAL_WIDTH+2+7)/8)*8-1:0]       m_axis_tdata
);
	import svn_pkg::*;

	localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW    = COORD_WIDTH;
	localparam int NW    = NORMAL_WIDTH;
	localparam int NUMW  = NW + 31;
	localparam int OUT_W = ((3*NORMAL_WIDTH+2+7)/8)*8;

	function automatic logic idx_ok(input logic [IDX_W-1:0] v);
		return 32'(v) < 32'(MAX_VERTICES);
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] v);
		return AW'(v);
	endfunction

	function automatic logic [MULW-1:0] mag_e(input logic signed [CW:0] v);
		logic signed [CW:0] t;
		t = v[CW] ? -v : v;
		return MULW'(t[CW-1:0]);
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
		input logic signed [NW-1:0] n);
		logic signed [SUM_W:0] t;
		t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
		if (t[SUM_W] != t[SUM_W-1]) begin
			return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return t[SUM_W-1:0];
	endfunction

	// input word fields
	op_t             in_op;
	logic [IDX_W-1:0] in_idx, in_a, in_b, in_c;
	logic            accept;

	assign in_op  = op_t'(s_axis_tuser);
	assign in_idx = s_axis_tdata[11:0];
	assign in_a   = s_axis_tdata[119:108];
	assign in_b   = s_axis_tdata[131:120];
	assign in_c   = s_axis_tdata[143:132];
	assign accept = s_axis_tvalid && s_axis_tready;

	state_t           state_q, state_d;
	op_t              op_q;
	stat_t            stat_q;
	logic             init_q;
	logic [AW-1:0]    clr_q;
	logic [2:0]       cnt_q;
	logic [1:0]       kk;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cor_q [3];
	logic             out_free;

	assign kk       = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
	assign out_free = !m_axis_tvalid || m_axis_tready;

	// stores
	logic              vram_we;
	logic [AW-1:0]     vram_raddr;
	logic [3*CW-1:0]   vram_rdata;
	logic              sram_we;
	logic [AW-1:0]     sram_waddr, sram_raddr;
	logic [SUM_WORD_W-1:0] sram_wdata, sram_rdata;

	// datapath registers
	logic [3*CW-1:0]         va_q, vb_q;
	logic signed [CW:0]      e1_q [3];
	logic signed [CW:0]      e2_q [3];
	logic [MULW-1:0]         mul_a, mul_b;
	logic                    mul_neg;
	logic [2*MULW-1:0]       prod_q;
	logic                    pneg_q;
	logic signed [VEC_W:0]   cr_q [3];
	logic signed [VEC_W:0]   pv;
	logic [2:0]              pidx;
	logic [VEC_W-1:0]        nm_q [3];
	logic                    neg_q [3];
	logic [VEC_W-1:0]        ov;
	logic                    norm_zero, norm_big8, norm_big1, norm_small8, norm_small1;
	logic [63:0]             s_q;
	logic [31:0]             m_q;
	logic signed [NW-1:0]    n_q [3];

	// arithmetic units
	logic              sq_start, sq_done;
	logic [31:0]       sq_root;
	logic              dv_start, dv_done;
	logic [NUMW-1:0]   dv_num;
	logic [NW-1:0]     dv_quo;

	assign ov          = nm_q[0] | nm_q[1] | nm_q[2];
	assign norm_zero   = ov == '0;
	assign norm_big8   = |ov[VEC_W-1:39];
	assign norm_big1   = |ov[VEC_W-1:31];
	assign norm_small8 = ov[30:23] == '0;
	assign norm_small1 = !ov[30];

	assign pidx = cnt_q - 3'd1;
	assign pv   = pneg_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});

	// sum store word unpack
	logic signed [SUM_W-1:0] rd_sx, rd_sy, rd_sz;
	logic [CNT_W-1:0]        rd_cnt;

	assign rd_sx  = sram_rdata[SUM_W-1:0];
	assign rd_sy  = sram_rdata[2*SUM_W-1:SUM_W];
	assign rd_sz  = sram_rdata[3*SUM_W-1:2*SUM_W];
	assign rd_cnt = sram_rdata[SUM_WORD_W-1:3*SUM_W];

	// next state and control
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		sq_start      = 1'b0;
		dv_start      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (accept) begin
					case (in_op)
						OP_LOAD:  state_d = ST_DONE;
						OP_TRI:   state_d = (idx_ok(in_a) && idx_ok(in_b) && idx_ok(in_c))
							? ST_TRI_A : ST_DONE;
						OP_READ:  state_d = idx_ok(in_idx) ? ST_RD_ISSUE : ST_DONE;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (clr_q == AW'(MAX_VERTICES - 1)) begin
					state_d = init_q ? ST_IDLE : ST_DONE;
				end
			end
			ST_TRI_A:    state_d = ST_TRI_B;
			ST_TRI_B:    state_d = ST_TRI_C;
			ST_TRI_C:    state_d = ST_TRI_EDGE;
			ST_TRI_EDGE: state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == 3'd6) begin
					state_d = ST_CROSS;
				end
			end
			ST_CROSS: state_d = ST_NORM;
			ST_NORM: begin
				if (norm_zero) begin
					state_d = ST_DONE;
				end else if (!norm_big1 && !norm_small1) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR: begin
				if (cnt_q == 3'd3) begin
					state_d = ST_ROOT_GO;
				end
			end
			ST_ROOT_GO: begin
				sq_start = 1'b1;
				state_d  = ST_ROOT;
			end
			ST_ROOT: begin
				if (sq_done) begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				dv_start = 1'b1;
				state_d  = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (dv_done) begin
					if (cnt_q == 3'd2) begin
						state_d = (op_q == OP_TRI) ? ST_ACC_RD : ST_DONE;
					end else begin
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_ACC_RD: state_d = ST_ACC_WR;
			ST_ACC_WR: state_d = (cnt_q == 3'd2) ? ST_DONE : ST_ACC_RD;
			ST_RD_ISSUE: state_d = ST_RD_SUM;
			ST_RD_SUM: state_d = (rd_cnt == '0) ? ST_DONE : ST_NORM;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			init_q        <= 1'b1;
			clr_q         <= '0;
			cnt_q         <= '0;
			stat_q        <= STAT_OK;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold a pending word until taken; load the next one as the old one leaves
			if (state_q == ST_DONE && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					clr_q <= '0;
					if (accept && in_op == OP_TRI &&
						!(idx_ok(in_a) && idx_ok(in_b) && idx_ok(in_c))) begin
						stat_q <= STAT_DEGEN;
					end else if (accept && in_op == OP_READ && !idx_ok(in_idx)) begin
						stat_q <= STAT_UNUSED;
					end else begin
						stat_q <= STAT_OK;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_VERTICES - 1)) begin
						init_q <= 1'b0;
					end
				end
				ST_MUL:   cnt_q <= (cnt_q == 3'd6) ? 3'd0 : cnt_q + 3'd1;
				ST_NORM: begin
					cnt_q <= '0;
					if (norm_zero) begin
						stat_q <= (op_q == OP_TRI) ? STAT_DEGEN : STAT_UNUSED;
					end
				end
				ST_SQR:   cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
				ST_DIV_WAIT: begin
					if (dv_done) begin
						cnt_q <= (cnt_q == 3'd2) ? 3'd0 : cnt_q + 3'd1;
					end
				end
				ST_ACC_WR: cnt_q <= cnt_q + 3'd1;
				ST_RD_SUM: begin
					if (rd_cnt == '0) begin
						stat_q <= STAT_UNUSED;
					end
				end
				default: ;
			endcase
		end
	end

	// shared multiplier operand select: cross terms, then squares
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		if (state_q == ST_MUL) begin
			case (cnt_q)
				3'd0: begin
					mul_a = mag_e(e1_q[1]); mul_b = mag_e(e2_q[2]);
					mul_neg = e1_q[1][CW] ^ e2_q[2][CW];
				end
				3'd1: begin
					mul_a = mag_e(e1_q[2]); mul_b = mag_e(e2_q[1]);
					mul_neg = !(e1_q[2][CW] ^ e2_q[1][CW]);
				end
				3'd2: begin
					mul_a = mag_e(e1_q[2]); mul_b = mag_e(e2_q[0]);
					mul_neg = e1_q[2][CW] ^ e2_q[0][CW];
				end
				3'd3: begin
					mul_a = mag_e(e1_q[0]); mul_b = mag_e(e2_q[2]);
					mul_neg = !(e1_q[0][CW] ^ e2_q[2][CW]);
				end
				3'd4: begin
					mul_a = mag_e(e1_q[0]); mul_b = mag_e(e2_q[1]);
					mul_neg = e1_q[0][CW] ^ e2_q[1][CW];
				end
				3'd5: begin
					mul_a = mag_e(e1_q[1]); mul_b = mag_e(e2_q[0]);
					mul_neg = !(e1_q[1][CW] ^ e2_q[0][CW]);
				end
				default: ;
			endcase
		end else if (state_q == ST_SQR) begin
			mul_a = MULW'(nm_q[kk][30:0]);
			mul_b = MULW'(nm_q[kk][30:0]);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		pneg_q <= mul_neg;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= in_op;
					idx_q    <= in_idx;
					cor_q[0] <= in_a;
					cor_q[1] <= in_b;
					cor_q[2] <= in_c;
				end
			end
			ST_TRI_B: va_q <= vram_rdata;
			ST_TRI_C: vb_q <= vram_rdata;
			ST_TRI_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= $signed({vb_q[i*CW+CW-1], vb_q[i*CW +: CW]})
						- $signed({va_q[i*CW+CW-1], va_q[i*CW +: CW]});
					e2_q[i] <= $signed({vram_rdata[i*CW+CW-1], vram_rdata[i*CW +: CW]})
						- $signed({va_q[i*CW+CW-1], va_q[i*CW +: CW]});
				end
			end
			ST_MUL: begin
				// fold the previous product into its cross term
				if (cnt_q != 3'd0) begin
					if (!pidx[0]) begin
						cr_q[pidx[2:1]] <= pv;
					end else begin
						cr_q[pidx[2:1]] <= cr_q[pidx[2:1]] + pv;
					end
				end
			end
			ST_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					nm_q[i]  <= cr_q[i][VEC_W] ? VEC_W'(-cr_q[i]) : VEC_W'(cr_q[i]);
					neg_q[i] <= cr_q[i][VEC_W];
				end
			end
			ST_RD_SUM: begin
				nm_q[0]  <= VEC_W'(rd_sx[SUM_W-1] ? 32'(-rd_sx) : 32'(rd_sx));
				nm_q[1]  <= VEC_W'(rd_sy[SUM_W-1] ? 32'(-rd_sy) : 32'(rd_sy));
				nm_q[2]  <= VEC_W'(rd_sz[SUM_W-1] ? 32'(-rd_sz) : 32'(rd_sz));
				neg_q[0] <= rd_sx[SUM_W-1];
				neg_q[1] <= rd_sy[SUM_W-1];
				neg_q[2] <= rd_sz[SUM_W-1];
			end
			ST_NORM: begin
				// bring the largest magnitude into [2^30, 2^31)
				for (int i = 0; i < 3; i++) begin
					if (norm_big8) begin
						nm_q[i] <= nm_q[i] >> 8;
					end else if (norm_big1) begin
						nm_q[i] <= nm_q[i] >> 1;
					end else if (norm_small8) begin
						nm_q[i] <= nm_q[i] << 8;
					end else if (norm_small1) begin
						nm_q[i] <= nm_q[i] << 1;
					end
				end
			end
			ST_SQR: begin
				if (cnt_q == 3'd0) begin
					s_q <= '0;
				end else begin
					s_q <= s_q + prod_q;
				end
			end
			ST_ROOT: begin
				if (sq_done) begin
					m_q <= sq_root;
				end
			end
			ST_DIV_WAIT: begin
				if (dv_done) begin
					if (neg_q[kk]) begin
						n_q[kk] <= -$signed(dv_quo);
					end else if (dv_quo[NW-1]) begin
						n_q[kk] <= {1'b0, {(NW-1){1'b1}}};
					end else begin
						n_q[kk] <= $signed(dv_quo);
					end
				end
			end
			default: ;
		endcase
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			if (op_q == OP_READ && stat_q == STAT_OK) begin
				m_axis_tdata <= OUT_W'({stat_q, n_q[2], n_q[1], n_q[0]});
			end else begin
				m_axis_tdata <= OUT_W'({stat_q, {(3*NW){1'b0}}});
			end
		end
	end

	// position store
	assign vram_we = accept && in_op == OP_LOAD && idx_ok(in_idx);

	always_comb begin
		case (state_q)
			ST_TRI_B: vram_raddr = to_addr(cor_q[1]);
			ST_TRI_C: vram_raddr = to_addr(cor_q[2]);
			default:  vram_raddr = to_addr(cor_q[0]);
		endcase
	end

	svn_ram #(
		.WIDTH (3 * CW),
		.DEPTH (MAX_VERTICES)
	) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (to_addr(in_idx)),
		.wdata ({s_axis_tdata[76 +: CW], s_axis_tdata[44 +: CW], s_axis_tdata[12 +: CW]}),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	// sum store: clearing sweep or read-modify-write of one corner
	logic [CNT_W-1:0] cnt_next;

	assign cnt_next   = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
	assign sram_we    = state_q == ST_CLEAR || state_q == ST_ACC_WR;
	assign sram_waddr = (state_q == ST_CLEAR) ? clr_q : to_addr(cor_q[kk]);
	assign sram_wdata = (state_q == ST_CLEAR) ? '0 :
		{cnt_next, sat_add(rd_sz, n_q[2]), sat_add(rd_sy, n_q[1]), sat_add(rd_sx, n_q[0])};
	assign sram_raddr = (state_q == ST_RD_ISSUE) ? to_addr(idx_q) : to_addr(cor_q[kk]);

	svn_ram #(
		.WIDTH (SUM_WORD_W),
		.DEPTH (MAX_VERTICES)
	) u_sram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (sram_waddr),
		.wdata (sram_wdata),
		.raddr (sram_raddr),
		.rdata (sram_rdata)
	);

	svn_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (s_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// rounded quotient: (c << (NW-1)) + M/2 over M
	assign dv_num = NUMW'({nm_q[kk][30:0], {(NW-1){1'b0}}}) + NUMW'(m_q[31:1]);

	svn_div #(
		.QW (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (m_q),
		.done   (dv_done),
		.quo    (dv_quo)
	);
endmodule

[hdl/svn_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module svn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/svn_isqrt.sv]
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on nothing; started by a one-cycle pulse, answers with a done pulse.
module svn_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign root  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd1) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= rad;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

[hdl/svn_div.sv]
// Restoring divider: (QW+31)-bit numerator by 32-bit divisor, QW quotient bits,
// one bit per cycle. The caller guarantees the quotient fits QW bits.
module svn_div #(
	parameter int QW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [QW+30:0]  num,
	input  logic [31:0]     den,
	output logic            done,
	output logic [QW-1:0]   quo
);
	localparam int CW = $clog2(QW + 1);

	logic [32:0]   rem_q;
	logic [QW-1:0] nlo_q;
	logic [31:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [32:0]   trial;
	logic          qbit;

	assign trial = {rem_q[31:0], nlo_q[QW-1]};
	assign qbit  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 33'(num[QW+30:QW]);
			nlo_q <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? trial - {1'b0, den_q} : trial;
			nlo_q <= nlo_q << 1;
			quo   <= {quo[QW-2:0], qbit};
		end
	end
endmodule
